[rtl/gps_synced_twelve_hour_clock_core_assert.svh]
// Assertion macros shared by the checker modules of the clock core.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef GPS_SYNCED_TWELVE_HOUR_CLOCK_CORE_ASSERT_SVH
`define GPS_SYNCED_TWELVE_HOUR_CLOCK_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSTC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("clock core assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GSTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("clock core assertion failed");

`endif

[rtl/gstc_pkg.sv]
// Shared types, constants and helper functions of the clock core.
// Used by the matcher, the timekeeper and the top level; depends on nothing.
package gstc_pkg;

	localparam int unsigned CAPTURE_LEN = 9;
	localparam int unsigned STORE_DEPTH = 6;

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_G      = 8'h47;
	localparam logic [7:0] CHAR_P      = 8'h50;
	localparam logic [7:0] CHAR_A      = 8'h41;
	localparam logic [7:0] CHAR_COMMA  = 8'h2C;
	localparam logic [7:0] ASCII_ZERO  = 8'd48;

	localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd0;
	localparam logic [1:0] REG_ZONE_HOURS       = 2'd1;
	localparam logic [1:0] REG_ZONE_MINUTES     = 2'd2;

	localparam logic [7:0] TICKS_RESET  = 8'd45;
	localparam logic [3:0] ZONE_H_RESET = 4'd5;
	localparam logic [5:0] ZONE_M_RESET = 6'd30;

	localparam logic [7:0] LIMIT_MINSEC = 8'd59;
	localparam logic [7:0] MINSEC_SPAN  = 8'd60;
	localparam logic [7:0] DAY_HOURS    = 8'd24;
	localparam logic [7:0] HALF_DAY     = 8'd12;
	localparam logic [7:0] LAST_PM_HOUR = 8'd23;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_DOLLAR  = 3'd1,
		ST_G       = 3'd2,
		ST_GP      = 3'd3,
		ST_GPG     = 3'd4,
		ST_GPGG    = 3'd5,
		ST_GPGGA   = 3'd6,
		ST_CAPTURE = 3'd7
	} match_state_t;

	typedef logic [STORE_DEPTH-1:0][7:0] gstc_store_t;

	typedef struct packed {
		logic        sync;
		gstc_store_t store;
	} gstc_capture_t;

	typedef struct packed {
		logic [7:0] hours;
		logic [7:0] minutes;
		logic [7:0] seconds;
		logic       pm;
		logic       led;
	} gstc_time_t;

	typedef struct packed {
		logic [4:0] tens;
		logic [3:0] ones;
	} gstc_digits_t;

	// Splits a byte into tens and ones; 205/2048 matches 1/10 for all byte values.
	function automatic gstc_digits_t div10(input logic [7:0] v);
		logic [15:0]  prod;
		logic [4:0]   q;
		logic [7:0]   rem;
		gstc_digits_t d;
		prod   = {8'd0, v} * 16'd205;
		q      = prod[15:11];
		rem    = v - ({3'd0, q} * 8'd10);
		d.tens = q;
		d.ones = rem[3:0];
		return d;
	endfunction

endpackage

[rtl/gstc_matcher.sv]
// Sentence matcher for the "$GPGGA," prefix and capture store of the time field.
// Depends on gstc_pkg for the state type, characters and capture length.
module gstc_matcher (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [7:0]             rx_byte,
	output gstc_pkg::gstc_capture_t cap
);
	import gstc_pkg::*;

	match_state_t state_q;
	match_state_t state_nx;
	logic [3:0]   count_q;
	logic [3:0]   count_nx;
	logic [4:0]   count_inc;
	logic         store_we;
	logic         sync;
	gstc_store_t  store_q;
	gstc_store_t  store_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= 4'd0;
		end else begin
			state_q <= state_nx;
			count_q <= count_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_q[count_q[2:0]] <= rx_byte;
		end
	end

	assign count_inc = {1'b0, count_q} + 5'd1;

	always_comb begin
		state_nx = state_q;
		count_nx = count_q;
		store_we = 1'b0;
		sync     = 1'b0;
		if (en) begin
			if (rx_byte == CHAR_DOLLAR) begin
				state_nx = ST_DOLLAR;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
					end
					ST_DOLLAR: begin
						if (rx_byte == CHAR_G) state_nx = ST_G;
					end
					ST_G: begin
						if (rx_byte == CHAR_P) state_nx = ST_GP;
					end
					ST_GP: begin
						if (rx_byte == CHAR_G) state_nx = ST_GPG;
					end
					ST_GPG: begin
						if (rx_byte == CHAR_G) state_nx = ST_GPGG;
					end
					ST_GPGG: begin
						if (rx_byte == CHAR_A) state_nx = ST_GPGGA;
					end
					ST_GPGGA: begin
						if (rx_byte == CHAR_COMMA) begin
							state_nx = ST_CAPTURE;
							count_nx = 4'd0;
						end
					end
					ST_CAPTURE: begin
						store_we = (count_q < 4'(STORE_DEPTH));
						if (count_inc >= 5'(CAPTURE_LEN)) begin
							count_nx = 4'd0;
							state_nx = ST_IDLE;
							sync     = 1'b1;
						end else begin
							count_nx = count_inc[3:0];
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		for (int i = 0; i < STORE_DEPTH; i++) begin
			store_nx[i] = (store_we && (count_q[2:0] == 3'(i))) ? rx_byte : store_q[i];
		end
	end

	assign cap.sync  = sync;
	assign cap.store = store_nx;

endmodule

[rtl/gstc_timekeeper.sv]
// Running clock: tick prescaler, second LED, h:m:s advance and load on a time sync.
// Depends on gstc_pkg for the capture and time types and the time limits.
module gstc_timekeeper (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    tick_en,
	input  gstc_pkg::gstc_capture_t cap,
	input  logic [7:0]              ticks_per_second,
	input  logic [3:0]              zone_hours,
	input  logic [5:0]              zone_minutes,
	output gstc_pkg::gstc_time_t    time_nx
);
	import gstc_pkg::*;

	logic [7:0] tick_q;
	logic [7:0] tick_nx;
	logic [8:0] tick_inc;
	gstc_time_t time_q;

	logic [7:0] h0;
	logic [7:0] h1;
	logic [7:0] h2;
	logic [7:0] h3;
	logic [7:0] m0;
	logic [7:0] m1;
	logic [7:0] s0;
	logic       pm_sync;
	logic [7:0] sec_inc;
	logic [7:0] min_inc;
	logic [7:0] hour_inc;

	function automatic logic [7:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] t;
		logic [7:0] u;
		t = hi - ASCII_ZERO;
		u = lo - ASCII_ZERO;
		return (t << 3) + (t << 1) + u;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= 8'd0;
			time_q <= '0;
		end else begin
			tick_q <= tick_nx;
			time_q <= time_nx;
		end
	end

	always_comb begin
		h0 = two_digits(cap.store[0], cap.store[1]) + {4'd0, zone_hours};
		m0 = two_digits(cap.store[2], cap.store[3]) + {2'd0, zone_minutes};
		s0 = two_digits(cap.store[4], cap.store[5]);
		if (m0 > LIMIT_MINSEC) begin
			m1 = m0 - MINSEC_SPAN;
			h1 = h0 + 8'd1;
		end else begin
			m1 = m0;
			h1 = h0;
		end
		h2      = (h1 > DAY_HOURS) ? (h1 - DAY_HOURS) : h1;
		pm_sync = (h2 >= HALF_DAY) && (h2 <= LAST_PM_HOUR);
		h3      = (h2 > HALF_DAY) ? (h2 - HALF_DAY) : h2;
	end

	assign tick_inc = {1'b0, tick_q} + 9'd1;
	assign sec_inc  = time_q.seconds + 8'd1;
	assign min_inc  = time_q.minutes + 8'd1;
	assign hour_inc = time_q.hours + 8'd1;

	always_comb begin
		tick_nx = tick_q;
		time_nx = time_q;
		if (cap.sync) begin
			time_nx.hours   = h3;
			time_nx.minutes = m1;
			time_nx.seconds = s0;
			time_nx.pm      = pm_sync;
			tick_nx         = 8'd0;
		end else if (tick_en) begin
			if (tick_inc <= {1'b0, ticks_per_second}) begin
				tick_nx = tick_inc[7:0];
			end else begin
				tick_nx     = 8'd0;
				time_nx.led = ~time_q.led;
				if (sec_inc > LIMIT_MINSEC) begin
					time_nx.seconds = 8'd0;
					if (min_inc > LIMIT_MINSEC) begin
						time_nx.minutes = 8'd0;
						time_nx.hours   = (hour_inc > HALF_DAY) ? 8'd0 : hour_inc;
					end else begin
						time_nx.minutes = min_inc;
					end
				end else begin
					time_nx.seconds = sec_inc;
				end
			end
		end
	end

endmodule

[rtl/gps_synced_twelve_hour_clock_core.sv]
// An accepted word waits in the input register, then moves to the result register
// once that is empty or drained. One word per cycle while m_tready keeps up; the
// two registers let a new word in while a finished result waits downstream.
// Reset (arst_n low, asynchronous): matcher idle, clock 00:00:00, LED and PM off,
// prescaler cleared, configuration back to 45 ticks, zone +5:30.
module gps_synced_twelve_hour_clock_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte[7:0]
	input  logic [0:0]  s_tuser,   // func[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// hour_tens[4:0], hour_ones[8:5], minute_tens[13:9], minute_ones[17:14],
	// second_tens[22:18], second_ones[26:23], pm_flag[27], second_led[28],
	// synced_now[29], zero fill[31:30]
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import gstc_pkg::*;

	logic          valid_s1;
	logic          func_s1;
	logic [7:0]    byte_s1;
	logic          advance;
	logic          out_valid_q;
	gstc_time_t    out_time_q;
	logic          out_sync_q;
	logic [7:0]    ticks_q;
	logic [3:0]    zone_h_q;
	logic [5:0]    zone_m_q;
	gstc_capture_t cap;
	gstc_time_t    time_nx;
	gstc_digits_t  hour_d;
	gstc_digits_t  min_d;
	gstc_digits_t  sec_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q  <= TICKS_RESET;
			zone_h_q <= ZONE_H_RESET;
			zone_m_q <= ZONE_M_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TICKS_PER_SECOND: ticks_q  <= cfg_data;
				REG_ZONE_HOURS:       zone_h_q <= cfg_data[3:0];
				REG_ZONE_MINUTES:     zone_m_q <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser[0];
			byte_s1 <= s_tdata;
		end
		if (advance) begin
			out_time_q <= time_nx;
			out_sync_q <= cap.sync;
		end
	end

	gstc_matcher u_matcher (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance && !func_s1),
		.rx_byte (byte_s1),
		.cap     (cap)
	);

	gstc_timekeeper u_timekeeper (
		.clk              (clk),
		.arst_n           (arst_n),
		.tick_en          (advance && func_s1),
		.cap              (cap),
		.ticks_per_second (ticks_q),
		.zone_hours       (zone_h_q),
		.zone_minutes     (zone_m_q),
		.time_nx          (time_nx)
	);

	assign hour_d = div10(out_time_q.hours);
	assign min_d  = div10(out_time_q.minutes);
	assign sec_d  = div10(out_time_q.seconds);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_sync_q, out_time_q.led, out_time_q.pm,
		sec_d.ones, sec_d.tens, min_d.ones, min_d.tens, hour_d.ones, hour_d.tens};

endmodule

[rtl/gstc_checker.sv]
// Port-level checker for the clock core and the bind that attaches it.
// Depends on the assertion macros in gps_synced_twelve_hour_clock_core_assert.svh.
`include "gps_synced_twelve_hour_clock_core_assert.svh"

module gstc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	`GSTC_ASSERT_NEXT(a_out_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`GSTC_ASSERT_NEXT(a_out_hold_data, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	`GSTC_ASSERT_SAME(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready)
	`GSTC_ASSERT_SAME(a_ready_when_drained, clk, arst_n, m_tvalid && m_tready, s_tready)
	`GSTC_ASSERT_SAME(a_ones_digits, clk, arst_n, m_tvalid,
		(m_tdata[8:5] <= 4'd9) && (m_tdata[17:14] <= 4'd9) && (m_tdata[26:23] <= 4'd9))

endmodule

bind gps_synced_twelve_hour_clock_core gstc_checker u_gstc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[dv/tb_gps_synced_twelve_hour_clock_core.sv]
// Self-checking testbench for the GPS synced twelve-hour clock core.
// Streams serial bytes and ticks through the core and checks every result word
// against an in-bench model of the sentence matcher and the clock; needs gstc_pkg.
module tb_gps_synced_twelve_hour_clock_core;
	import gstc_pkg::*;

	typedef enum logic {
		FUNC_BYTE = 1'b0,
		FUNC_TICK = 1'b1
	} word_kind_t;

	typedef struct packed {
		word_kind_t kind;
		logic [7:0] rx;
	} serial_word_t;

	typedef struct packed {
		logic [1:0] zero_fill;
		logic       synced_now;
		logic       second_led;
		logic       pm_flag;
		logic [3:0] second_ones;
		logic [4:0] second_tens;
		logic [3:0] minute_ones;
		logic [4:0] minute_tens;
		logic [3:0] hour_ones;
		logic [4:0] hour_tens;
	} clock_face_t;

	localparam logic [6:0][7:0] GGA_TAG = {CHAR_COMMA, CHAR_A, CHAR_G, CHAR_G, CHAR_P, CHAR_G,
		CHAR_DOLLAR};
	localparam logic [4:0] GRAB_LEN = 5'(CAPTURE_LEN);
	localparam logic [3:0] GRAB_DEPTH = 4'(STORE_DEPTH);
	localparam logic [7:0] WRONG_CHAR = 8'h58;
	localparam int unsigned PHASE_WORDS = 265;
	localparam int unsigned PHASES = 5;
	localparam int unsigned LONG_HOLD = 240;
	localparam int unsigned HOLD_AT_RESULT = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic [0:0]  s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [7:0]  cfg_data = 8'd0;

	// Model state of the core and its settings.
	match_state_t nmea_state = ST_IDLE;
	logic [3:0]   grab_count = 4'd0;
	logic [7:0]   grab_bytes [STORE_DEPTH];
	logic [7:0]   prescale = 8'd0;
	logic [7:0]   clk_h = 8'd0;
	logic [7:0]   clk_m = 8'd0;
	logic [7:0]   clk_s = 8'd0;
	logic         pm_state = 1'b0;
	logic         led_state = 1'b0;
	logic [7:0]   set_tps = TICKS_RESET;
	logic [3:0]   set_zone_h = ZONE_H_RESET;
	logic [5:0]   set_zone_m = ZONE_M_RESET;

	serial_word_t serial_words [$];
	clock_face_t  pending_faces [$];
	int unsigned  phase_words = 0;
	int unsigned  words_sent = 0;
	int unsigned  faces_seen = 0;
	int unsigned  mismatches = 0;
	int unsigned  sync_count = 0;
	int unsigned  second_count = 0;
	int unsigned  reg_writes = 0;
	int unsigned  tx_wait = 0;
	int unsigned  rx_wait = 0;
	int unsigned  hold_left = 0;
	bit           tx_calm = 1'b1;
	bit           rx_calm = 1'b0;

	gps_synced_twelve_hour_clock_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [7:0] ascii_pair(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] t;
		logic [7:0] u;
		t = hi - ASCII_ZERO;
		u = lo - ASCII_ZERO;
		return 8'(t * 8'd10) + u;
	endfunction

	function automatic logic [7:0] prefix_char(input match_state_t st);
		case (st)
			ST_DOLLAR: return CHAR_G;
			ST_G:      return CHAR_P;
			ST_GP:     return CHAR_G;
			ST_GPG:    return CHAR_G;
			ST_GPGG:   return CHAR_A;
			default:   return CHAR_COMMA;
		endcase
	endfunction

	function automatic void load_utc();
		logic [7:0] h;
		logic [7:0] m;
		h = ascii_pair(grab_bytes[0], grab_bytes[1]) + {4'd0, set_zone_h};
		m = ascii_pair(grab_bytes[2], grab_bytes[3]) + {2'd0, set_zone_m};
		if (m > LIMIT_MINSEC) begin
			m = m - MINSEC_SPAN;
			h = h + 8'd1;
		end
		if (h > DAY_HOURS)
			h = h - DAY_HOURS;
		pm_state = (h >= HALF_DAY) && (h <= LAST_PM_HOUR);
		if (h > HALF_DAY)
			h = h - HALF_DAY;
		clk_h = h;
		clk_m = m;
		clk_s = ascii_pair(grab_bytes[4], grab_bytes[5]);
		prescale = 8'd0;
		sync_count++;
	endfunction

	function automatic void count_tick();
		if ({1'b0, prescale} + 9'd1 <= {1'b0, set_tps}) begin
			prescale = prescale + 8'd1;
			return;
		end
		prescale = 8'd0;
		led_state = ~led_state;
		second_count++;
		clk_s = clk_s + 8'd1;
		if (clk_s > LIMIT_MINSEC) begin
			clk_s = 8'd0;
			clk_m = clk_m + 8'd1;
			if (clk_m > LIMIT_MINSEC) begin
				clk_m = 8'd0;
				clk_h = clk_h + 8'd1;
				if (clk_h > HALF_DAY)
					clk_h = 8'd0;
			end
		end
	endfunction

	function automatic logic take_char(input logic [7:0] b);
		if (b == CHAR_DOLLAR) begin
			nmea_state = ST_DOLLAR;
		end else if (nmea_state == ST_CAPTURE) begin
			if (grab_count < GRAB_DEPTH)
				grab_bytes[grab_count] = b;
			if ({1'b0, grab_count} + 5'd1 >= GRAB_LEN) begin
				grab_count = 4'd0;
				nmea_state = ST_IDLE;
				load_utc();
				return 1'b1;
			end
			grab_count = grab_count + 4'd1;
		end else if (nmea_state != ST_IDLE && b == prefix_char(nmea_state)) begin
			nmea_state = match_state_t'(nmea_state + 3'd1);
			if (nmea_state == ST_CAPTURE)
				grab_count = 4'd0;
		end
		return 1'b0;
	endfunction

	function automatic clock_face_t advance_clock(input serial_word_t w);
		clock_face_t f;
		f = '0;
		if (w.kind == FUNC_TICK)
			count_tick();
		else
			f.synced_now = take_char(w.rx);
		f.hour_tens = 5'(clk_h / 8'd10);
		f.hour_ones = 4'(clk_h % 8'd10);
		f.minute_tens = 5'(clk_m / 8'd10);
		f.minute_ones = 4'(clk_m % 8'd10);
		f.second_tens = 5'(clk_s / 8'd10);
		f.second_ones = 4'(clk_s % 8'd10);
		f.pm_flag = pm_state;
		f.second_led = led_state;
		return f;
	endfunction

	function automatic string face_diff(input clock_face_t w, input clock_face_t g);
		string s;
		s = "";
		if (w.hour_tens != g.hour_tens)
			s = {s, $sformatf(" hour_tens exp %0d got %0d", w.hour_tens, g.hour_tens)};
		if (w.hour_ones != g.hour_ones)
			s = {s, $sformatf(" hour_ones exp %0d got %0d", w.hour_ones, g.hour_ones)};
		if (w.minute_tens != g.minute_tens)
			s = {s, $sformatf(" minute_tens exp %0d got %0d", w.minute_tens, g.minute_tens)};
		if (w.minute_ones != g.minute_ones)
			s = {s, $sformatf(" minute_ones exp %0d got %0d", w.minute_ones, g.minute_ones)};
		if (w.second_tens != g.second_tens)
			s = {s, $sformatf(" second_tens exp %0d got %0d", w.second_tens, g.second_tens)};
		if (w.second_ones != g.second_ones)
			s = {s, $sformatf(" second_ones exp %0d got %0d", w.second_ones, g.second_ones)};
		if (w.pm_flag != g.pm_flag)
			s = {s, $sformatf(" pm_flag exp %0d got %0d", w.pm_flag, g.pm_flag)};
		if (w.second_led != g.second_led)
			s = {s, $sformatf(" second_led exp %0d got %0d", w.second_led, g.second_led)};
		if (w.synced_now != g.synced_now)
			s = {s, $sformatf(" synced_now exp %0d got %0d", w.synced_now, g.synced_now)};
		if (w.zero_fill != g.zero_fill)
			s = {s, $sformatf(" zero_fill exp %0d got %0d", w.zero_fill, g.zero_fill)};
		return s;
	endfunction

	// Sender: offers queued words, with a drawn gap (none while calm) after each one.
	always @(posedge clk or negedge arst_n) begin : word_feed
		serial_word_t w;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'd0;
			s_tuser <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				pending_faces.push_back(advance_clock({word_kind_t'(s_tuser), s_tdata}));
				words_sent++;
			end
			if (tx_wait > 0) begin
				tx_wait--;
				s_tvalid <= 1'b0;
			end else if (serial_words.size() != 0) begin
				w = serial_words.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= w.rx;
				s_tuser <= w.kind;
				if ($urandom_range(0, 29) == 0)
					tx_calm = !tx_calm;
				tx_wait = tx_calm ? 0 : $urandom_range(0, 18);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: checks each result word and paces m_tready.
	always @(posedge clk or negedge arst_n) begin : face_check
		clock_face_t got;
		string diff;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = clock_face_t'(m_tdata);
				faces_seen++;
				if (pending_faces.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result %0d arrived with nothing expected: %h", faces_seen,
							m_tdata);
				end else begin
					diff = face_diff(pending_faces.pop_front(), got);
					if (diff != "") begin
						mismatches++;
						if (mismatches <= 10)
							$display("Result %0d mismatch:%s", faces_seen, diff);
					end
				end
				if (faces_seen == HOLD_AT_RESULT)
					hold_left = LONG_HOLD;
				if ($urandom_range(0, 29) == 0)
					rx_calm = !rx_calm;
				rx_wait = rx_calm ? 0 : $urandom_range(0, 18);
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic push_word(input word_kind_t kind, input logic [7:0] rx);
		serial_words.push_back({kind, rx});
		phase_words++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		push_word(FUNC_BYTE, b);
	endtask

	task automatic push_ticks(input int unsigned n);
		repeat (n) push_word(FUNC_TICK, 8'($urandom));
	endtask

	task automatic sprinkle_ticks();
		if ($urandom_range(0, 5) == 0)
			push_ticks($urandom_range(1, 3));
	endtask

	task automatic push_pair(input int unsigned v);
		push_byte(ASCII_ZERO + 8'(v / 10));
		sprinkle_ticks();
		push_byte(ASCII_ZERO + 8'(v % 10));
		sprinkle_ticks();
	endtask

	task automatic push_tail(input int unsigned n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom);
			if (b == CHAR_DOLLAR)
				b = CHAR_COMMA;
			push_byte(b);
		end
	endtask

	task automatic push_sentence();
		int unsigned pick;
		int unsigned cut;
		push_ticks($urandom_range(0, 4));
		pick = $urandom_range(0, 19);
		if (pick == 18) begin
			// Line noise, mostly ignored by an idle matcher; not counted.
			repeat ($urandom_range(1, 4)) serial_words.push_back({FUNC_BYTE, 8'($urandom)});
		end else if (pick == 19) begin
			push_ticks($urandom_range(10, 60));
		end else begin
			cut = (pick >= 16) ? $urandom_range(1, 7) : 8;
			for (int i = 0; i < 7; i++) begin
				if (i == cut)
					push_tail(1);
				push_byte(GGA_TAG[i]);
			end
			if (cut == 7) begin
				// Capture cut short; the next dollar sign restarts the matcher.
				push_tail($urandom_range(0, CAPTURE_LEN - 1));
			end else begin
				if (pick < 10 || pick >= 16) begin
					push_pair($urandom_range(0, 23));
					push_pair($urandom_range(0, 59));
					push_pair($urandom_range(0, 59));
				end else if (pick < 13) begin
					push_pair($urandom_range(0, 24));
					push_pair(59);
					push_pair($urandom_range(55, 59));
				end else if (pick < 15) begin
					repeat (6) push_byte(ASCII_ZERO + 8'($urandom_range(0, 9)));
				end else begin
					push_tail(6);
				end
				push_tail(CAPTURE_LEN - 6);
				if (pick >= 10 && pick < 13)
					push_ticks($urandom_range(40, 90));
			end
		end
	endtask

	task automatic write_setting(input logic [1:0] idx, input logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TICKS_PER_SECOND: set_tps = value;
			REG_ZONE_HOURS:       set_zone_h = value[3:0];
			REG_ZONE_MINUTES:     set_zone_m = value[5:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic drain();
		while (serial_words.size() != 0 || s_tvalid || pending_faces.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// An idle byte, a wrong character, a dollar sign while capturing, then a
		// full capture whose minutes carry and whose hour folds past 24.
		push_byte(8'h00);
		push_byte(CHAR_DOLLAR);
		push_byte(CHAR_G);
		push_byte(WRONG_CHAR);
		for (int i = 2; i < 7; i++)
			push_byte(GGA_TAG[i]);
		push_byte(ASCII_ZERO + 8'd1);
		for (int i = 0; i < 7; i++)
			push_byte(GGA_TAG[i]);
		push_pair(23);
		push_pair(59);
		push_pair(59);
		push_byte(8'hFF);
		push_byte(ASCII_ZERO + 8'd9);
		push_byte(ASCII_ZERO + 8'd9);
		push_ticks(2);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				1: begin
					write_setting(REG_TICKS_PER_SECOND, 8'd0);
					write_setting(REG_ZONE_HOURS, 8'd0);
					write_setting(REG_ZONE_MINUTES, 8'd0);
				end
				2: begin
					write_setting(REG_TICKS_PER_SECOND, 8'd255);
					write_setting(REG_ZONE_HOURS, 8'd12);
					write_setting(REG_ZONE_MINUTES, 8'd59);
				end
				3: begin
					write_setting(REG_TICKS_PER_SECOND, 8'($urandom_range(1, 5)));
					write_setting(REG_ZONE_HOURS, 8'($urandom_range(0, 12)));
					write_setting(REG_ZONE_MINUTES, 8'($urandom_range(0, 59)));
				end
				4: begin
					write_setting(REG_TICKS_PER_SECOND, 8'($urandom_range(0, 2)));
					write_setting(REG_ZONE_HOURS, 8'd12);
					write_setting(REG_ZONE_MINUTES, 8'($urandom_range(0, 59)));
				end
				default: ;
			endcase
			@(negedge clk);
			if (p != 0)
				phase_words = 0;
			while (phase_words < PHASE_WORDS)
				push_sentence();
			drain();
		end

		$display("Sent %0d words over %0d settings, %0d register writes.", words_sent,
			PHASES, reg_writes);
		$display("Saw %0d time captures and %0d elapsed seconds; %0d mismatches.",
			sync_count, second_count, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#4000000;
		$display("Timed out with %0d results still expected.", pending_faces.size());
		$display("FAIL");
		$finish;
	end

endmodule

[gps_synced_twelve_hour_clock_core.f]
+incdir+rtl
rtl/gstc_pkg.sv
rtl/gstc_matcher.sv
rtl/gstc_timekeeper.sv
rtl/gps_synced_twelve_hour_clock_core.sv
rtl/gstc_checker.sv
dv/tb_gps_synced_twelve_hour_clock_core.sv
